/* src/rlat_pkg.sv */
// ----------------------------------------------------------------------------
// rlat_pkg
// Shared types and constants of the replication leader ack tracker.
// ----------------------------------------------------------------------------
package rlat_pkg;

  localparam int WINDOW_DEF       = 64;
  localparam int MAX_REPLICAS_DEF = 16;
  localparam int QDEPTH           = 4;

  typedef enum logic [1:0] {
    OP_NEW  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_PREPARE = 3'd0,
    K_REPLY   = 3'd1,
    K_DROP    = 3'd2,
    K_IGNORE  = 3'd3,
    K_RECORD  = 3'd4
  } kind_t;

  localparam logic REG_NUM_REPLICAS = 1'b0;
  localparam logic REG_MAX_WAITING  = 1'b1;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] txn_handle;
    logic [31:0] client_req;
    logic [15:0] client_tag;
    logic [31:0] ack_index;
    logic [3:0]  ack_replica;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] dest_mask;
    logic [31:0] seq_index;
    logic [31:0] txn_ref;
    logic [31:0] reply_id;
    logic [15:0] reply_client;
    logic [31:0] committed_total;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [4:0] num_replicas;
    logic [5:0] max_waiting;
  } cfg_t;

endpackage

/* src/rlat_ram.sv */
// ----------------------------------------------------------------------------
// rlat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/rlat_front.sv */
// ----------------------------------------------------------------------------
// rlat_front
// Accepts input items, discards unused opcodes and queues the rest.
// ----------------------------------------------------------------------------
module rlat_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rlat_pkg::cmd_t in_cmd,
  input  logic          q_pop,
  output logic          q_valid,
  output rlat_pkg::cmd_t q_head
);
  import rlat_pkg::*;

  localparam int QW = $clog2(QDEPTH);

  cmd_t          mem_r [QDEPTH];
  logic [QW-1:0] wptr_r;
  logic [QW-1:0] rptr_r;
  logic [QW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign in_ready = (cnt_r < (QW+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_head   = mem_r[rptr_r];
  assign push     = in_valid && in_ready && (in_cmd.opcode != OP_NONE);
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QW'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QW'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* src/rlat_back.sv */
// ----------------------------------------------------------------------------
// rlat_back
// Executes queued items against the slot ring and forms the results.
// ----------------------------------------------------------------------------
module rlat_back #(
  parameter int WINDOW       = rlat_pkg::WINDOW_DEF,
  parameter int MAX_REPLICAS = rlat_pkg::MAX_REPLICAS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rlat_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  rlat_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output rlat_pkg::res_t out_res
);
  import rlat_pkg::*;

  localparam int SW = $clog2(WINDOW);
  localparam int OW = $clog2(WINDOW + 1);
  localparam int DW = 80;
  localparam int AW = 17;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_NEW    = 13'b0000000000010,
    S_ACK    = 13'b0000000000100,
    S_ARD    = 13'b0000000001000,
    S_AUPD   = 13'b0000000010000,
    S_REPLY  = 13'b0000000100000,
    S_COMMIT = 13'b0000001000000,
    S_CCHK   = 13'b0000010000000,
    S_TFIND  = 13'b0000100000000,
    S_TFCHK  = 13'b0001000000000,
    S_TSCAN  = 13'b0010000000000,
    S_TRD    = 13'b0100000000000,
    S_TEMIT  = 13'b1000000000000
  } state_t;

  state_t        state_r;
  cmd_t          cmd_r;
  logic [31:0]   next_index_r;
  logic [31:0]   commit_count_r;
  logic [OW-1:0] waiting_r;
  logic [SW-1:0] commit_slot_r;
  logic [SW-1:0] next_slot_r;
  logic [SW-1:0] slot_r;
  logic [SW-1:0] scan_slot_r;
  logic [OW-1:0] off_r;
  logic [OW-1:0] last_off_r;
  logic [OW-1:0] span_r;
  logic          found_r;
  res_t          out_r;
  logic          out_valid_r;

  logic [4:0]    eff_n;
  logic [16:0]   low_ones;
  logic [15:0]   fmask;
  logic [31:0]   span32;
  logic [31:0]   off32;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] ack_slot;
  logic          in_span;
  logic          drop;
  logic          can_emit;
  logic [AW-1:0] ack_rd;
  logic          slot_ready;
  logic [DW-1:0] data_rd;
  logic [15:0]   acks_new;
  logic [4:0]    ack_cnt;
  logic          ack_full;
  logic          ack_we;
  logic [SW-1:0] ack_waddr;
  logic [AW-1:0] ack_wdata;
  logic          data_we;
  logic [SW-1:0] rd_addr;
  logic          emit;
  res_t          res_c;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SW'(WINDOW - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    eff_n = cfg.num_replicas;
    if (eff_n < 5'd2) eff_n = 5'd2;
    if (32'(eff_n) > MAX_REPLICAS) eff_n = 5'(MAX_REPLICAS);
    if (eff_n > 5'd16) eff_n = 5'd16;
  end

  assign low_ones = (17'd1 << eff_n) - 17'd1;
  assign fmask    = low_ones[15:0] & 16'hFFFE;
  assign span32   = next_index_r - commit_count_r;
  assign off32    = cmd_r.ack_index - commit_count_r;
  assign slot_sum = {1'b0, commit_slot_r} + {1'b0, off32[SW-1:0]};
  assign ack_slot = (slot_sum >= (SW+1)'(WINDOW)) ? SW'(slot_sum - (SW+1)'(WINDOW))
                                                  : slot_sum[SW-1:0];
  assign in_span  = (off32 < span32);
  assign drop     = (32'(waiting_r) > 32'(cfg.max_waiting)) || (span32 >= 32'(WINDOW));
  assign can_emit = !out_valid_r || out_ready;
  assign slot_ready = ack_rd[AW-1];
  assign acks_new = ack_rd[15:0] | (16'd1 << cmd_r.ack_replica);

  always_comb begin
    ack_cnt = '0;
    for (int i = 0; i < 16; i++) begin
      ack_cnt = ack_cnt + 5'(acks_new[i]);
    end
  end

  assign ack_full  = (ack_cnt >= eff_n - 5'd1);
  assign data_we   = (state_r == S_NEW) && can_emit && !drop;
  assign ack_we    = data_we || ((state_r == S_AUPD) && can_emit && !slot_ready);
  assign ack_waddr = (state_r == S_NEW) ? next_slot_r : slot_r;
  assign ack_wdata = (state_r == S_NEW) ? '0 : {ack_full, acks_new};
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  always_comb begin
    rd_addr = slot_r;
    if (state_r == S_COMMIT) begin
      rd_addr = commit_slot_r;
    end else if ((state_r == S_TFIND) || (state_r == S_TFCHK) || (state_r == S_TSCAN) ||
                 (state_r == S_TRD) || (state_r == S_TEMIT)) begin
      rd_addr = scan_slot_r;
    end
  end

  rlat_ram #(.WIDTH(AW), .DEPTH(WINDOW)) u_ack_ram (
    .clk     (clk),
    .wr_en   (ack_we),
    .wr_addr (ack_waddr),
    .wr_data (ack_wdata),
    .rd_addr (rd_addr),
    .rd_data (ack_rd)
  );

  rlat_ram #(.WIDTH(DW), .DEPTH(WINDOW)) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (next_slot_r),
    .wr_data ({cmd_r.txn_handle, cmd_r.client_req, cmd_r.client_tag}),
    .rd_addr (rd_addr),
    .rd_data (data_rd)
  );

  always_comb begin
    emit  = 1'b0;
    res_c = '0;
    res_c.committed_total = commit_count_r;
    res_c.last = 1'b1;
    unique case (state_r)
      S_NEW: begin
        emit = can_emit;
        res_c.seq_index = next_index_r;
        res_c.txn_ref   = cmd_r.txn_handle;
        if (drop) begin
          res_c.kind         = K_DROP;
          res_c.reply_id     = cmd_r.client_req;
          res_c.reply_client = cmd_r.client_tag;
        end else begin
          res_c.kind      = K_PREPARE;
          res_c.dest_mask = fmask;
        end
      end
      S_ACK: begin
        emit = can_emit && !in_span;
        res_c.kind      = K_IGNORE;
        res_c.seq_index = cmd_r.ack_index;
      end
      S_AUPD: begin
        emit = can_emit;
        res_c.seq_index = cmd_r.ack_index;
        if (slot_ready) begin
          res_c.kind = K_IGNORE;
        end else begin
          res_c.kind      = K_RECORD;
          res_c.dest_mask = acks_new;
          res_c.last      = !ack_full;
        end
      end
      S_REPLY: begin
        emit = can_emit;
        res_c.kind         = K_REPLY;
        res_c.seq_index    = cmd_r.ack_index;
        res_c.txn_ref      = data_rd[79:48];
        res_c.reply_id     = data_rd[47:16];
        res_c.reply_client = data_rd[15:0];
      end
      S_TEMIT: begin
        emit = can_emit;
        res_c.kind      = K_PREPARE;
        res_c.dest_mask = fmask & ~ack_rd[15:0];
        res_c.seq_index = commit_count_r + 32'(off_r);
        res_c.txn_ref   = data_rd[79:48];
        res_c.last      = (off_r == last_off_r);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res_c;
    end
    if (state_r == S_IDLE && q_valid) begin
      cmd_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      next_index_r   <= '0;
      commit_count_r <= '0;
      waiting_r      <= '0;
      commit_slot_r  <= '0;
      next_slot_r    <= '0;
      slot_r         <= '0;
      scan_slot_r    <= '0;
      off_r          <= '0;
      last_off_r     <= '0;
      span_r         <= '0;
      found_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            off_r       <= '0;
            found_r     <= 1'b0;
            scan_slot_r <= commit_slot_r;
            span_r      <= span32[OW-1:0];
            case (q_head.opcode)
              OP_NEW:  state_r <= S_NEW;
              OP_ACK:  state_r <= S_ACK;
              OP_TICK: state_r <= S_TFIND;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_NEW: begin
          if (can_emit) begin
            if (!drop) begin
              waiting_r    <= waiting_r + 1'b1;
              next_index_r <= next_index_r + 32'd1;
              next_slot_r  <= slot_inc(next_slot_r);
            end
            state_r <= S_IDLE;
          end
        end
        S_ACK: begin
          if (in_span) begin
            slot_r  <= ack_slot;
            state_r <= S_ARD;
          end else if (can_emit) begin
            state_r <= S_IDLE;
          end
        end
        S_ARD: begin
          state_r <= S_AUPD;
        end
        S_AUPD: begin
          if (can_emit) begin
            state_r <= (!slot_ready && ack_full) ? S_REPLY : S_IDLE;
          end
        end
        S_REPLY: begin
          if (can_emit) begin
            if (waiting_r != '0) begin
              waiting_r <= waiting_r - 1'b1;
            end
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_r <= S_CCHK;
        end
        S_CCHK: begin
          if ((commit_count_r != next_index_r) && slot_ready) begin
            commit_count_r <= commit_count_r + 32'd1;
            commit_slot_r  <= slot_inc(commit_slot_r);
            state_r        <= S_COMMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_TFIND: begin
          if (off_r < span_r) begin
            state_r <= S_TFCHK;
          end else begin
            off_r       <= '0;
            scan_slot_r <= commit_slot_r;
            state_r     <= found_r ? S_TSCAN : S_IDLE;
          end
        end
        S_TFCHK: begin
          if (!slot_ready) begin
            found_r    <= 1'b1;
            last_off_r <= off_r;
          end
          off_r       <= off_r + 1'b1;
          scan_slot_r <= slot_inc(scan_slot_r);
          state_r     <= S_TFIND;
        end
        S_TSCAN: begin
          state_r <= S_TRD;
        end
        S_TRD: begin
          if (!slot_ready) begin
            state_r <= S_TEMIT;
          end else begin
            off_r       <= off_r + 1'b1;
            scan_slot_r <= slot_inc(scan_slot_r);
            state_r     <= S_TSCAN;
          end
        end
        S_TEMIT: begin
          if (can_emit) begin
            if (off_r == last_off_r) begin
              state_r <= S_IDLE;
            end else begin
              off_r       <= off_r + 1'b1;
              scan_slot_r <= slot_inc(scan_slot_r);
              state_r     <= S_TSCAN;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef NO_ASSERTIONS
  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (next_index_r - commit_count_r) <= 32'(WINDOW))
    else $error("slot ring span exceeds window");

  a_waiting_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(waiting_r) <= (next_index_r - commit_count_r))
    else $error("awaiting count exceeds open span");

  a_commit_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_count_r != $past(commit_count_r)) |-> $past(state_r == S_CCHK))
    else $error("commit count moved outside the commit walk");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("pending result overwritten");
`endif

endmodule

/* src/replication_leader_ack_tracker.sv */
// ----------------------------------------------------------------------------
// replication_leader_ack_tracker
// Leader-side prepare/ack tracker over a ring of transaction slots.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    opcode, handle, ids, ack fields
//   out      output     out_valid/out_ready  kind, mask, index, refs, last
//   cfg      input      psel/penable         num_replicas, max_waiting
//
// A new request holds the back end in S_NEW. An ack outside the open span is
// answered from S_ACK, one inside it updates its slot via S_ARD and S_AUPD,
// and a completing ack adds S_REPLY and the in-order commit walk through
// S_COMMIT and S_CCHK. A resend tick reads every open slot, then walks again
// up to the last pending slot with a prepare per pending slot, bound by the
// single registered read port of the slot RAMs. A slot is open exactly when
// its index lies in the span, so reset clears only counters. A stalled output
// holds one result in its register while up to four items queue at the front.
// ----------------------------------------------------------------------------
module replication_leader_ack_tracker #(
  parameter int WINDOW       = rlat_pkg::WINDOW_DEF,
  parameter int MAX_REPLICAS = rlat_pkg::MAX_REPLICAS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_txn_handle,
  input  logic [31:0] in_client_req,
  input  logic [15:0] in_client_tag,
  input  logic [31:0] in_ack_index,
  input  logic [3:0]  in_ack_replica,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_dest_mask,
  output logic [31:0] out_seq_index,
  output logic [31:0] out_txn_ref,
  output logic [31:0] out_reply_id,
  output logic [15:0] out_reply_client,
  output logic [31:0] out_committed_total,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlat_pkg::*;

  cfg_t cfg_r;
  cmd_t in_cmd;
  cmd_t q_head;
  logic q_valid;
  logic q_pop;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_WAITING) ? {26'd0, cfg_r.max_waiting}
                                                : {27'd0, cfg_r.num_replicas};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_replicas <= 5'd3;
      cfg_r.max_waiting  <= 6'd63;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NUM_REPLICAS) begin
        cfg_r.num_replicas <= pwdata[4:0];
      end else begin
        cfg_r.max_waiting <= pwdata[5:0];
      end
    end
  end

  assign in_cmd.opcode      = opcode_t'(in_opcode);
  assign in_cmd.txn_handle  = in_txn_handle;
  assign in_cmd.client_req  = in_client_req;
  assign in_cmd.client_tag  = in_client_tag;
  assign in_cmd.ack_index   = in_ack_index;
  assign in_cmd.ack_replica = in_ack_replica;

  rlat_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  rlat_back #(.WINDOW(WINDOW), .MAX_REPLICAS(MAX_REPLICAS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind            = res.kind;
  assign out_dest_mask       = res.dest_mask;
  assign out_seq_index       = res.seq_index;
  assign out_txn_ref         = res.txn_ref;
  assign out_reply_id        = res.reply_id;
  assign out_reply_client    = res.reply_client;
  assign out_committed_total = res.committed_total;
  assign out_last            = res.last;

endmodule
